// File: design/psv_pkg.sv
// shared types, constants and arithmetic helpers for the plucked string voice
package psv_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 18;
	localparam int PROD_W     = 2 * ACC_W;
	localparam int PERIOD_W   = 11;
	localparam int STRETCH_W  = 16;
	localparam int GAIN_W     = 17;
	localparam int COEFF_W    = 16;
	localparam int SEED_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int MAX_DELAY_DEF = 1024;

	localparam logic [PERIOD_W-1:0]       PERIOD_RST  = PERIOD_W'(256);
	localparam logic [STRETCH_W-1:0]      STRETCH_RST = STRETCH_W'(32768);
	localparam logic [GAIN_W-1:0]         DECAY_RST   = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0]         BLEND_RST   = GAIN_W'(65536);
	localparam logic signed [COEFF_W-1:0] COEFF_RST   = '0;
	localparam logic [SEED_W-1:0]         SEED_RST    = SEED_W'(44257);
	localparam logic [SEED_W-1:0]         LFSR_TAPS   = 16'hB400;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEED    = 3'd5;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_GEN  = 1'b1;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_WR,
		ST_MUL_MIX,
		ST_SUM_MIX,
		ST_MUL_GAIN,
		ST_SUM_GAIN,
		ST_MUL_TUNE,
		ST_SUM_TUNE,
		ST_GEN_WR
	} state_t;

	typedef enum logic [1:0] {
		MUL_MIX,
		MUL_GAIN,
		MUL_TUNE
	} mul_sel_t;

	typedef struct packed {
		logic     clear_wr;
		logic     accept;
		logic     load_wr;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_mix;
		logic     sum_gain;
		logic     sum_tune;
		logic     gen_wr;
	} psv_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} psv_stat_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v
	);
		logic signed [ACC_W-1:0] c;
		c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
		return c[SAMPLE_W-1:0];
	endfunction

	// round half up, drop 16 fraction bits
	function automatic logic signed [ACC_W-1:0] round_q16(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-16){1'b0}}, 16'h8000});
		return t[16 +: ACC_W];
	endfunction

	// round half up, drop 15 fraction bits
	function automatic logic signed [ACC_W-1:0] round_q15(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-15){1'b0}}, 15'h4000});
		return t[15 +: ACC_W];
	endfunction

endpackage

// File: design/psv_ram.sv
// generic simple dual port ram, one write port and one registered read port
module psv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/psv_dp.sv
// datapath: registers, delay line, lfsr, shared multiplier and output register
module psv_dp #(
	parameter int MAX_DELAY = psv_pkg::MAX_DELAY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  psv_pkg::psv_cmd_t                     cmd,
	output psv_pkg::psv_stat_t                    stat,
	input  logic                                  cfg_wr_en,
	input  logic [psv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [psv_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [psv_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [psv_pkg::SAMPLE_W-1:0]   sample_out
);
	import psv_pkg::*;

	localparam int AW = $clog2(MAX_DELAY);
	localparam int PW = (AW + 1 > PERIOD_W) ? AW + 1 : PERIOD_W;

	// configuration
	logic [PERIOD_W-1:0]       period_q;
	logic [STRETCH_W-1:0]      stretch_q;
	logic [GAIN_W-1:0]         decay_q;
	logic [GAIN_W-1:0]         blend_q;
	logic signed [COEFF_W-1:0] coeff_q;
	logic [SEED_W-1:0]         lfsr_q;

	// voice state
	logic [AW-1:0]              line_pos_q;
	logic [AW-1:0]              clr_q;
	logic signed [SAMPLE_W-1:0] older_q;
	logic signed [SAMPLE_W-1:0] ap_in_q;
	logic signed [SAMPLE_W-1:0] ap_out_q;
	logic                       out_valid_q;

	// working registers
	logic [AW-1:0]              addr_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    mix_q;
	logic                       flip_q;
	logic signed [SAMPLE_W-1:0] val_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic [PW-1:0]              p_eff;
	logic [PW-1:0]              per_ext;
	logic [AW-1:0]              pos_eff;
	logic [PW-1:0]              pos_inc;
	logic [SEED_W-1:0]          lfsr_nx;
	logic signed [ACC_W-1:0]    op_a;
	logic signed [ACC_W-1:0]    op_b;
	logic signed [PROD_W-1:0]   prod_nx;
	logic signed [ACC_W-1:0]    gain_r;
	logic signed [SAMPLE_W-1:0] y_nx;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [SAMPLE_W-1:0]        ram_wdata;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] a_rd;

	// effective period and position
	always_comb begin
		per_ext = PW'(period_q);
		if (per_ext < PW'(2)) begin
			p_eff = PW'(2);
		end else if (per_ext > PW'(MAX_DELAY)) begin
			p_eff = PW'(MAX_DELAY);
		end else begin
			p_eff = per_ext;
		end
		pos_eff = (PW'(line_pos_q) >= p_eff) ? '0 : line_pos_q;
		pos_inc = PW'(addr_q) + PW'(1);
	end

	assign lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	assign a_rd    = $signed(ram_rdata);

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_MIX: begin
				op_a = $signed({2'b00, stretch_q});
				op_b = ACC_W'(older_q) - ACC_W'(a_rd);
			end
			MUL_GAIN: begin
				op_a = mix_q;
				op_b = $signed({1'b0, decay_q});
			end
			MUL_TUNE: begin
				op_a = ACC_W'(coeff_q);
				op_b = ACC_W'(val_q) - ACC_W'(ap_out_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod_nx = op_a * op_b;
		gain_r  = round_q16(prod_q);
		y_nx    = sat_sample(ACC_W'(ap_in_q) + round_q15(prod_q));
	end

	// delay line write port
	always_comb begin
		ram_we    = cmd.clear_wr | cmd.load_wr | cmd.gen_wr;
		ram_waddr = cmd.clear_wr ? clr_q : addr_q;
		if (cmd.clear_wr) begin
			ram_wdata = '0;
		end else if (cmd.load_wr) begin
			ram_wdata = sample_q;
		end else begin
			ram_wdata = y_q;
		end
	end

	psv_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_DELAY)
	) u_line (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (cmd.accept),
		.rd_addr(pos_eff),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			stretch_q   <= STRETCH_RST;
			decay_q     <= DECAY_RST;
			blend_q     <= BLEND_RST;
			coeff_q     <= COEFF_RST;
			lfsr_q      <= SEED_RST;
			line_pos_q  <= '0;
			clr_q       <= '0;
			older_q     <= '0;
			ap_in_q     <= '0;
			ap_out_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PERIOD:  period_q  <= cfg_data[PERIOD_W-1:0];
					REG_STRETCH: stretch_q <= cfg_data[STRETCH_W-1:0];
					REG_DECAY:   decay_q   <= cfg_data[GAIN_W-1:0];
					REG_BLEND:   blend_q   <= cfg_data[GAIN_W-1:0];
					REG_COEFF:   coeff_q   <= $signed(cfg_data[COEFF_W-1:0]);
					// zero seed would lock the lfsr
					REG_SEED:    lfsr_q    <= (cfg_data[SEED_W-1:0] == '0) ?
						SEED_W'(1) : cfg_data[SEED_W-1:0];
					default: ;
				endcase
			end else if (cmd.mul_en && cmd.mul_sel == MUL_MIX) begin
				lfsr_q <= lfsr_nx;
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.sum_tune) begin
				ap_in_q  <= val_q;
				ap_out_q <= y_nx;
			end
			if (cmd.load_wr || cmd.gen_wr) begin
				older_q    <= cmd.load_wr ? a_rd : a_q;
				line_pos_q <= (pos_inc >= p_eff) ? '0 : addr_q + AW'(1);
			end
			if (cmd.gen_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q   <= pos_eff;
			sample_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_nx;
		end
		if (cmd.mul_en && cmd.mul_sel == MUL_MIX) begin
			a_q    <= a_rd;
			flip_q <= ({1'b0, lfsr_nx} >= blend_q);
		end
		if (cmd.sum_mix) begin
			mix_q <= ACC_W'(a_q) + round_q16(prod_q);
		end
		if (cmd.sum_gain) begin
			val_q <= sat_sample(flip_q ? -gain_r : gain_r);
		end
		if (cmd.sum_tune) begin
			y_q <= y_nx;
		end
		if (cmd.gen_wr) begin
			sample_out_q <= y_q;
		end
	end

	assign stat.clear_last = (clr_q == AW'(MAX_DELAY - 1));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = sample_out_q;

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_wr |=> out_valid_q && sample_out_q == $past(y_q))
		else $error("result not presented after write-back");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(line_pos_q) < PW'(MAX_DELAY))
		else $error("line position beyond delay line");

endmodule

// File: design/psv_ctrl.sv
// controller: clearing pass and per-beat sequencing of the shared multiplier
module psv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                action,
	output logic                in_ready,
	input  psv_pkg::psv_stat_t  stat,
	output psv_pkg::psv_cmd_t   cmd
);
	import psv_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (action == ACT_GEN) ? ST_MUL_MIX : ST_LOAD_WR;
				end
			end
			ST_LOAD_WR:  state_nx = ST_IDLE;
			ST_MUL_MIX:  state_nx = ST_SUM_MIX;
			ST_SUM_MIX:  state_nx = ST_MUL_GAIN;
			ST_MUL_GAIN: state_nx = ST_SUM_GAIN;
			ST_SUM_GAIN: state_nx = ST_MUL_TUNE;
			ST_MUL_TUNE: state_nx = ST_SUM_TUNE;
			ST_SUM_TUNE: state_nx = ST_GEN_WR;
			ST_GEN_WR: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear_wr = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOAD_WR: cmd.load_wr = 1'b1;
			ST_MUL_MIX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MIX;
			end
			ST_SUM_MIX: cmd.sum_mix = 1'b1;
			ST_MUL_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN;
			end
			ST_SUM_GAIN: cmd.sum_gain = 1'b1;
			ST_MUL_TUNE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TUNE;
			end
			ST_SUM_TUNE: cmd.sum_tune = 1'b1;
			ST_GEN_WR:   cmd.gen_wr = stat.out_free;
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("ready while a beat is in progress");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("clearing pass restarted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_wr |-> stat.out_free)
		else $error("result written over a pending beat");

endmodule

// File: design/plucked_string_voice.sv
// top level of the plucked string voice
// a generate beat runs from idle through the mix, gain and tune multiply and
//   sum states to the line write-back, which waits for a free output register;
//   the single multiplier is used three times per sample, one beat at a time
// reset: a clearing pass zeroes the whole delay line, in_ready stays low
//   meanwhile; configuration writes are taken during the pass
module plucked_string_voice #(
	parameter int MAX_DELAY = psv_pkg::MAX_DELAY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [psv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [psv_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [psv_pkg::SAMPLE_W-1:0] sample_out
);
	import psv_pkg::*;

	psv_cmd_t  cmd;
	psv_stat_t stat;

	psv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (action),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	psv_dp #(
		.MAX_DELAY(MAX_DELAY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

endmodule
